// ===== rtl/vertex_transform_cull_project_defines.svh =====
// ----------------------------------------------------------------------------
// Vertex transform and cull assertion macros
// Shared concurrent assertion forms used by the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_CULL_PROJECT_DEFINES_SVH
`define VERTEX_TRANSFORM_CULL_PROJECT_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define VTCP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// The condition must never be true outside of reset.
`define VTCP_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== rtl/vtcp_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex transform and cull package
// Shared types and constants for the transform, cull and projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package vtcp_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COS_HEADING = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIN_HEADING = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EYE_HEIGHT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SIDE_MODE   = 3'd5;

	localparam logic [1:0] SIDE_DROP_GE   = 2'd0;
	localparam logic [1:0] SIDE_DROP_LT   = 2'd1;
	localparam logic [1:0] SIDE_DROP_NONE = 2'd2;

	localparam logic signed [15:0] COS_RESET = 16'sd16384;

	localparam int MID_DEPTH_DEF = 8;
	localparam int OUT_DEPTH_DEF = 16;

	localparam int NEAR_LIMIT = 10;
	localparam int FAR_LIMIT  = 600;
	localparam int X_LIMIT    = 256;
	localparam int DEN_BIAS   = 10;
	localparam int CENTER_X   = 160;
	localparam int CENTER_ROW = 100;

	localparam int DIV_W           = 24;
	localparam int STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES      = DIV_W / STEPS_PER_STAGE;

	typedef struct packed {
		logic signed [15:0] camera_x;
		logic signed [15:0] camera_y;
		logic signed [15:0] cos_heading;
		logic signed [15:0] sin_heading;
		logic signed [15:0] eye_height;
		logic [1:0]         side_mode;
	} cfg_t;

	// Camera-space vertex that passed the view volume test.
	typedef struct packed {
		logic signed [8:0]  rx;
		logic [9:0]         depth;
		logic signed [15:0] z;
		logic [15:0]        attr;
	} view_t;

	typedef struct packed {
		logic signed [9:0]  screen_x;
		logic [9:0]         view_depth;
		logic signed [15:0] screen_row;
		logic [15:0]        attr;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/vertex_transform_cull_project.sv =====
// A kept vertex goes through the front stages, the middle queue, the divide and the result queue.
// Throughput: one vertex per cycle while full is low; every stage, the four rotation multipliers
// and the twelve-stage divide pipeline (two quotient bits per stage) take a new word each cycle.
// Dropped and culled vertices produce no word.
// Reset: arst_n is asynchronous; it empties both queues and the pipelines and loads the
// register reset values (identity heading, no camera offset, side test off).
`default_nettype none

`include "vertex_transform_cull_project_defines.svh"

// ----------------------------------------------------------------------------
// Vertex transform, cull and project
// Translates, rotates, culls and perspective-projects one vertex per word.
// ----------------------------------------------------------------------------
module vertex_transform_cull_project #(
	parameter int MID_DEPTH = vtcp_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH = vtcp_pkg::OUT_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [vtcp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [vtcp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic signed [15:0]                  vert_x,
	input  wire logic signed [15:0]                  vert_y,
	input  wire logic signed [15:0]                  vert_z,
	input  wire logic [15:0]                         attr_in,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic signed [9:0]                        screen_x,
	output logic [9:0]                               view_depth,
	output logic signed [15:0]                       screen_row,
	output logic [15:0]                              attr_out
);

	localparam int MCW = $clog2(MID_DEPTH + 1);
	localparam int OCW = $clog2(OUT_DEPTH + 1);

	// The configuration registers feed the front end directly. The user must change them only
	// while idle, so no word in flight sees a mix of old and new settings; nothing enforces it.
	vtcp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.camera_x    <= '0;
			cfg_q.camera_y    <= '0;
			cfg_q.cos_heading <= vtcp_pkg::COS_RESET;
			cfg_q.sin_heading <= '0;
			cfg_q.eye_height  <= '0;
			cfg_q.side_mode   <= vtcp_pkg::SIDE_DROP_NONE;
		end else if (cfg_we) begin
			case (cfg_index)
				vtcp_pkg::REG_CAMERA_X:    cfg_q.camera_x    <= cfg_data;
				vtcp_pkg::REG_CAMERA_Y:    cfg_q.camera_y    <= cfg_data;
				vtcp_pkg::REG_COS_HEADING: cfg_q.cos_heading <= cfg_data;
				vtcp_pkg::REG_SIN_HEADING: cfg_q.sin_heading <= cfg_data;
				vtcp_pkg::REG_EYE_HEIGHT:  cfg_q.eye_height  <= cfg_data;
				vtcp_pkg::REG_SIDE_MODE:   cfg_q.side_mode   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic              in_accept;
	logic              mid_push;
	vtcp_pkg::view_t   mid_wdata;
	logic [1:0]        front_occ;
	logic              mid_pop;
	vtcp_pkg::view_t   mid_rdata;
	logic              mid_full;
	logic              mid_empty;
	logic [MCW-1:0]    mid_count;
	logic [MCW:0]      mid_load;
	logic              res_push;
	vtcp_pkg::result_t res_wdata;
	vtcp_pkg::result_t res_rdata;
	logic              out_full;
	logic [OCW-1:0]    out_count;
	logic              res_taken;

	// The front end never stalls: a word is taken only when the middle queue has room
	// for it and for every word still in the three front stages.
	assign mid_load  = {1'b0, mid_count} + (MCW + 1)'(front_occ);
	assign full      = mid_load >= (MCW + 1)'(MID_DEPTH);
	assign in_accept = push && !full;

	vtcp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (in_accept),
		.vert_x     (vert_x),
		.vert_y     (vert_y),
		.vert_z     (vert_z),
		.attr_in    (attr_in),
		.view_valid (mid_push),
		.view_data  (mid_wdata),
		.occupancy  (front_occ)
	);

	vtcp_fifo #(
		.WIDTH ($bits(vtcp_pkg::view_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.full   (mid_full),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	// The back end holds a credit for every result slot it has claimed, so the divide
	// pipeline also runs without stalls and the result queue cannot overflow.
	vtcp_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (mid_empty),
		.q_data    (mid_rdata),
		.q_pop     (mid_pop),
		.res_push  (res_push),
		.res_data  (res_wdata),
		.res_taken (res_taken)
	);

	vtcp_fifo #(
		.WIDTH ($bits(vtcp_pkg::result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.pop    (pop),
		.rdata  (res_rdata),
		.full   (out_full),
		.empty  (empty),
		.count  (out_count)
	);

	assign res_taken  = pop && !empty;
	assign screen_x   = res_rdata.screen_x;
	assign view_depth = res_rdata.view_depth;
	assign screen_row = res_rdata.screen_row;
	assign attr_out   = res_rdata.attr;

	`VTCP_ASSERT_NEVER(a_mid_overflow, clk, arst_n, mid_push && mid_full, "middle queue overflow")
	`VTCP_ASSERT_NEVER(a_out_overflow, clk, arst_n, res_push && out_full, "result queue overflow")
	`VTCP_ASSERT_NEVER(a_mid_underflow, clk, arst_n, mid_pop && mid_empty, "middle queue underflow")
	`VTCP_ASSERT_IMPL(a_mid_bound, clk, arst_n, 1'b1, mid_load <= (MCW + 1)'(MID_DEPTH), "middle queue reservation exceeded")
	`VTCP_ASSERT_NEVER(a_out_bound, clk, arst_n, out_count > OCW'(OUT_DEPTH), "result queue count out of range")

endmodule

`default_nettype wire

// ===== rtl/vtcp_fifo.sv =====
// ----------------------------------------------------------------------------
// Vertex transform and cull word queue
// Small register-file FIFO with a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module vtcp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       pop,
	output logic [WIDTH-1:0]                rdata,
	output logic                            full,
	output logic                            empty,
	output logic [$clog2(DEPTH+1)-1:0]      count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/vtcp_front.sv =====
// ----------------------------------------------------------------------------
// Vertex transform and cull front end
// Side test, camera translation, Q14 rotation and view volume classification.
// ----------------------------------------------------------------------------
`default_nettype none

module vtcp_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire vtcp_pkg::cfg_t      cfg,
	input  wire logic                accept,
	input  wire logic signed [15:0]  vert_x,
	input  wire logic signed [15:0]  vert_y,
	input  wire logic signed [15:0]  vert_z,
	input  wire logic [15:0]         attr_in,
	output logic                     view_valid,
	output vtcp_pkg::view_t          view_data,
	output logic [1:0]               occupancy
);

	logic               drop;
	logic               valid_s1, valid_s2, valid_s3;
	logic signed [15:0] tx_s1, ty_s1, z_s1, z_s2, z_s3;
	logic [15:0]        attr_s1, attr_s2, attr_s3;
	logic signed [31:0] txc_s2, tys_s2, tyc_s2, txs_s2;
	logic signed [31:0] rx_sum, depth_sum;
	logic signed [15:0] rx_s3, depth_s3;
	logic signed [15:0] abs_rx;
	logic               keep;

	always_comb begin
		case (cfg.side_mode)
			vtcp_pkg::SIDE_DROP_GE: drop = vert_x >= vert_y;
			vtcp_pkg::SIDE_DROP_LT: drop = vert_x < vert_y;
			default:                drop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept && !drop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tx_s1   <= cfg.camera_x - vert_x;
			ty_s1   <= vert_y - cfg.camera_y;
			z_s1    <= vert_z + cfg.eye_height;
			attr_s1 <= attr_in;
		end
		if (valid_s1) begin
			txc_s2  <= tx_s1 * cfg.cos_heading;
			tys_s2  <= ty_s1 * cfg.sin_heading;
			tyc_s2  <= ty_s1 * cfg.cos_heading;
			txs_s2  <= tx_s1 * cfg.sin_heading;
			z_s2    <= z_s1;
			attr_s2 <= attr_s1;
		end
		if (valid_s2) begin
			rx_s3    <= rx_sum[29:14];
			depth_s3 <= depth_sum[29:14];
			z_s3     <= z_s2;
			attr_s3  <= attr_s2;
		end
	end

	assign rx_sum    = txc_s2 - tys_s2;
	assign depth_sum = tyc_s2 + txs_s2;

	// The magnitude only matters once the range checks have passed.
	assign abs_rx = rx_s3[15] ? -rx_s3 : rx_s3;
	assign keep = (depth_s3 > 16'(vtcp_pkg::NEAR_LIMIT)) && (depth_s3 < 16'(vtcp_pkg::FAR_LIMIT))
		&& (rx_s3 > -16'sd256) && (rx_s3 < 16'(vtcp_pkg::X_LIMIT)) && (abs_rx < depth_s3);

	assign view_valid       = valid_s3 && keep;
	assign view_data.rx     = rx_s3[8:0];
	assign view_data.depth  = depth_s3[9:0];
	assign view_data.z      = z_s3;
	assign view_data.attr   = attr_s3;

	assign occupancy = {1'b0, valid_s1} + {1'b0, valid_s2} + {1'b0, valid_s3};

endmodule

`default_nettype wire

// ===== rtl/vtcp_back.sv =====
// ----------------------------------------------------------------------------
// Vertex transform and cull back end
// Pipelined perspective divide for screen x and screen row.
// ----------------------------------------------------------------------------
`default_nettype none

module vtcp_back #(
	parameter int OUT_DEPTH = vtcp_pkg::OUT_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire vtcp_pkg::view_t   q_data,
	output logic                   q_pop,
	output logic                   res_push,
	output vtcp_pkg::result_t      res_data,
	input  wire logic              res_taken
);

	localparam int CW = $clog2(OUT_DEPTH + 1);
	localparam int NS = vtcp_pkg::DIV_STAGES;
	localparam int DW = vtcp_pkg::DIV_W;

	typedef struct packed {
		logic [9:0]    rem;
		logic [DW-1:0] nq;
	} div_state_t;

	// One restoring step: the numerator shifts out at the top, quotient bits in at the bottom.
	function automatic div_state_t div_step(div_state_t st, logic [9:0] den);
		logic [10:0] t;
		div_state_t  r;
		t = {st.rem, st.nq[DW-1]};
		if (t >= {1'b0, den}) begin
			r.rem = 10'(t - {1'b0, den});
			r.nq  = {st.nq[DW-2:0], 1'b1};
		end else begin
			r.rem = t[9:0];
			r.nq  = {st.nq[DW-2:0], 1'b0};
		end
		return r;
	endfunction

	logic [CW-1:0]  cred_q;
	logic [NS:0]    vld_s;
	div_state_t     x_s [0:NS];
	div_state_t     z_s [0:NS];
	logic [9:0]     den_s [0:NS];
	logic [9:0]     depth_s [0:NS];
	logic [15:0]    attr_s [0:NS];
	logic [NS:0]    xneg_s;
	logic [NS:0]    zneg_s;
	logic [8:0]     abs_rx;
	logic [15:0]    abs_z;
	logic [DW-1:0]  qx;
	logic [DW-1:0]  qz;

	assign q_pop  = !q_empty && (cred_q < CW'(OUT_DEPTH));
	assign abs_rx = q_data.rx[8] ? 9'(-q_data.rx) : q_data.rx;
	assign abs_z  = q_data.z[15] ? 16'(-q_data.z) : q_data.z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cred_q <= '0;
			vld_s  <= '0;
		end else begin
			if (q_pop && !res_taken) begin
				cred_q <= cred_q + 1'b1;
			end else if (res_taken && !q_pop) begin
				cred_q <= cred_q - 1'b1;
			end
			vld_s <= {vld_s[NS-1:0], q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			x_s[0]     <= '{rem: '0, nq: {7'd0, abs_rx, 8'd0}};
			z_s[0]     <= '{rem: '0, nq: {abs_z, 8'd0}};
			den_s[0]   <= q_data.depth + 10'(vtcp_pkg::DEN_BIAS);
			depth_s[0] <= q_data.depth;
			attr_s[0]  <= q_data.attr;
			xneg_s[0]  <= q_data.rx[8];
			zneg_s[0]  <= q_data.z[15];
		end
	end

	for (genvar k = 1; k <= NS; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (vld_s[k-1]) begin
				x_s[k]     <= div_step(div_step(x_s[k-1], den_s[k-1]), den_s[k-1]);
				z_s[k]     <= div_step(div_step(z_s[k-1], den_s[k-1]), den_s[k-1]);
				den_s[k]   <= den_s[k-1];
				depth_s[k] <= depth_s[k-1];
				attr_s[k]  <= attr_s[k-1];
				xneg_s[k]  <= xneg_s[k-1];
				zneg_s[k]  <= zneg_s[k-1];
			end
		end
	end

	// Quotients truncate toward zero, so the sign is applied to the magnitude.
	assign qx = xneg_s[NS] ? -x_s[NS].nq : x_s[NS].nq;
	assign qz = zneg_s[NS] ? -z_s[NS].nq : z_s[NS].nq;

	assign res_push            = vld_s[NS];
	assign res_data.screen_x   = qx[9:0] + 10'(vtcp_pkg::CENTER_X);
	assign res_data.view_depth = depth_s[NS];
	assign res_data.screen_row = qz[15:0] + 16'(vtcp_pkg::CENTER_ROW);
	assign res_data.attr       = attr_s[NS];

endmodule

`default_nettype wire

// ===== verif/vertex_transform_cull_project_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex transform, cull and project testbench
// Sends world vertices through the block under several camera settings and
// checks every projected word against a predictor of the transform, the
// side test, the view volume cull and the perspective divide.
// ----------------------------------------------------------------------------
module vertex_transform_cull_project_tb;

	// Side mode value that the block treats like "drop nothing".
	localparam logic [1:0] SIDE_SPARE = 2'd3;
	// Register indexes past the end of the register file; writes are ignored.
	localparam logic [vtcp_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
	localparam logic [vtcp_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;
	localparam int STALL_MAX = 18;
	localparam int DRAIN_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 3000;

	// Predicts projected words and checks them in order.
	class projection_board;
		vtcp_pkg::cfg_t      cam;
		vtcp_pkg::result_t   pending[$];
		int        errors;
		int        vertices_seen;
		int        words_checked;

		function new();
			cam = '{camera_x: 16'sd0, camera_y: 16'sd0, cos_heading: vtcp_pkg::COS_RESET,
				sin_heading: 16'sd0, eye_height: 16'sd0,
				side_mode: vtcp_pkg::SIDE_DROP_NONE};
			errors = 0;
			vertices_seen = 0;
			words_checked = 0;
		endfunction

		function void write_reg(logic [vtcp_pkg::CFG_IDX_W-1:0] idx,
				logic [vtcp_pkg::CFG_DATA_W-1:0] value);
			case (idx)
				vtcp_pkg::REG_CAMERA_X: cam.camera_x = value;
				vtcp_pkg::REG_CAMERA_Y: cam.camera_y = value;
				vtcp_pkg::REG_COS_HEADING: cam.cos_heading = value;
				vtcp_pkg::REG_SIN_HEADING: cam.sin_heading = value;
				vtcp_pkg::REG_EYE_HEIGHT: cam.eye_height = value;
				vtcp_pkg::REG_SIDE_MODE: cam.side_mode = value[1:0];
				default: ;
			endcase
		endfunction

		// Works out the word that one accepted vertex produces, if any.
		function void note_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
				logic signed [15:0] vz, logic [15:0] attr);
			logic signed [15:0] tx, ty, zz;
			logic [31:0] prod;
			int rx, depth, den, qx, qz;
			bit drop;
			vtcp_pkg::result_t r;
			vertices_seen++;
			drop = 0;
			if (cam.side_mode == vtcp_pkg::SIDE_DROP_GE)
				drop = (vx >= vy);
			else if (cam.side_mode == vtcp_pkg::SIDE_DROP_LT)
				drop = (vx < vy);
			if (drop)
				return;
			tx = cam.camera_x - vx;
			ty = vy - cam.camera_y;
			prod = tx * cam.cos_heading - ty * cam.sin_heading;
			rx = $signed(prod[29:14]);
			prod = ty * cam.cos_heading + tx * cam.sin_heading;
			depth = $signed(prod[29:14]);
			zz = vz + cam.eye_height;
			if (!(depth > vtcp_pkg::NEAR_LIMIT && depth < vtcp_pkg::FAR_LIMIT
					&& rx > -vtcp_pkg::X_LIMIT && rx < vtcp_pkg::X_LIMIT))
				return;
			if ((rx < 0 ? -rx : rx) >= depth)
				return;
			den = depth + vtcp_pkg::DEN_BIAS;
			qx = (rx * 256) / den;
			qz = (int'(zz) * 256) / den;
			r.screen_x = 10'(qx + vtcp_pkg::CENTER_X);
			r.view_depth = 10'(depth);
			r.screen_row = 16'(qz + vtcp_pkg::CENTER_ROW);
			r.attr = attr;
			pending.push_back(r);
		endfunction

		task report(string what, int got, int want);
			$display("mismatch on %s at word %0d: got %0d, want %0d", what,
				words_checked, got, want);
			errors++;
		endtask

		task check_word(vtcp_pkg::result_t got);
			vtcp_pkg::result_t want;
			if (pending.size() == 0) begin
				report("unexpected word", 1, 0);
				return;
			end
			want = pending.pop_front();
			if (got.screen_x !== want.screen_x)
				report("screen_x", got.screen_x, want.screen_x);
			if (got.view_depth !== want.view_depth)
				report("view_depth", got.view_depth, want.view_depth);
			if (got.screen_row !== want.screen_row)
				report("screen_row", got.screen_row, want.screen_row);
			if (got.attr !== want.attr)
				report("attr_out", got.attr, want.attr);
			words_checked++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [vtcp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [vtcp_pkg::CFG_DATA_W-1:0] cfg_data;
	logic push, full, empty, pop;
	logic signed [15:0] vert_x, vert_y, vert_z;
	logic [15:0] attr_in;
	logic signed [9:0] screen_x;
	logic [9:0] view_depth;
	logic signed [15:0] screen_row;
	logic [15:0] attr_out;

	projection_board board = new();
	bit send_idle;
	bit pop_idle;
	int quiet_cycles;

	vertex_transform_cull_project u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .push(push), .full(full), .vert_x(vert_x),
		.vert_y(vert_y), .vert_z(vert_z), .attr_in(attr_in), .empty(empty),
		.pop(pop), .screen_x(screen_x), .view_depth(view_depth),
		.screen_row(screen_row), .attr_out(attr_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: all outputs are sampled at the edge, before the block updates
	// them. A stall count is drawn after every accepted word when idling is on.
	initial begin
		int stall;
		stall = 0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				board.check_word('{screen_x: screen_x, view_depth: view_depth,
					screen_row: screen_row, attr: attr_out});
				stall = pop_idle ? $urandom_range(0, STALL_MAX) : 0;
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// The watchdog counts cycles in which no word moves on either side.
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d words outstanding",
					board.pending.size());
				$display("[vertex_transform_cull_project] ERROR");
				$finish;
			end
		end
	end

	task write_reg(logic [vtcp_pkg::CFG_IDX_W-1:0] idx, logic [vtcp_pkg::CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.write_reg(idx, value);
	endtask

	task set_camera(logic [15:0] cx, logic [15:0] cy, logic [15:0] c, logic [15:0] s,
			logic [15:0] eye, logic [1:0] mode);
		write_reg(vtcp_pkg::REG_CAMERA_X, cx);
		write_reg(vtcp_pkg::REG_CAMERA_Y, cy);
		write_reg(vtcp_pkg::REG_COS_HEADING, c);
		write_reg(vtcp_pkg::REG_SIN_HEADING, s);
		write_reg(vtcp_pkg::REG_EYE_HEIGHT, eye);
		write_reg(vtcp_pkg::REG_SIDE_MODE, {14'd0, mode});
	endtask

	// Holds push until the word is taken, then optionally idles before the next.
	task send_vertex(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz, logic [15:0] attr);
		int gap;
		push <= 1'b1;
		vert_x <= vx;
		vert_y <= vy;
		vert_z <= vz;
		attr_in <= attr;
		do @(posedge clk); while (full);
		board.note_vertex(vx, vy, vz, attr);
		gap = send_idle ? $urandom_range(0, STALL_MAX) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Picks a vertex that lands at a chosen camera-space point near the view volume, so that
	// random vertices fall both inside and outside the cull. The rest are raw random words.
	task send_random_vertex();
		int rx, depth, tx, ty, c, s;
		logic [15:0] vx, vy;
		if ($urandom_range(0, 3) != 0) begin
			rx = $urandom_range(0, 640) - 320;
			depth = $urandom_range(0, 690) - 40;
			c = board.cam.cos_heading;
			s = board.cam.sin_heading;
			tx = (rx * c + depth * s) >>> 14;
			ty = (depth * c - rx * s) >>> 14;
			vx = 16'(board.cam.camera_x - tx);
			vy = 16'(ty + board.cam.camera_y);
		end else begin
			vx = 16'($urandom());
			vy = 16'($urandom());
		end
		send_vertex(vx, vy, 16'($urandom()), 16'($urandom()));
	endtask

	// Lets every word drain and any dropped vertex leave the pipeline.
	task wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		push = 1'b0;
		vert_x = '0;
		vert_y = '0;
		vert_z = '0;
		attr_in = '0;
		send_idle = 1'b0;
		pop_idle = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under reset settings: depth is world y and the screen
		// offset is minus world x, so the cull edges are easy to hit.
		send_vertex(16'sd0, 16'sd100, 16'sd0, 16'h0000);
		send_vertex(-16'sd255, 16'sd300, 16'sd50, 16'hFFFF);
		send_vertex(16'sd255, 16'sd300, -16'sd50, 16'hA5A5);
		send_vertex(16'sd0, 16'sd11, 16'sd32767, 16'h5A5A);
		send_vertex(16'sd0, 16'sd599, -16'sd32768, 16'h0001);
		send_vertex(16'sd0, 16'sd10, 16'sd1, 16'h8000);
		send_vertex(16'sd0, 16'sd600, 16'sd1, 16'h1234);
		send_vertex(-16'sd256, 16'sd400, 16'sd0, 16'h4321);
		send_vertex(16'sd256, 16'sd400, 16'sd0, 16'h4322);
		send_vertex(-16'sd50, 16'sd50, 16'sd0, 16'h7777);
		send_vertex(16'sd49, 16'sd50, 16'sd0, 16'h7778);
		send_vertex(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFF);
		send_vertex(16'sh8000, 16'sh7FFF, 16'sh8000, 16'h0000);
		send_vertex(16'sd0, 16'sd21, 16'sh7FFF, 16'hF0F0);
		send_vertex(-16'sd10, 16'sd11, 16'sh8000, 16'h0F0F);
		wait_idle();

		// Side mode extremes and heading swaps, each with random vertices.
		// Writes to unused indexes go in first and must change nothing.
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_UNUSED_A, 16'hBEEF);
			write_reg(REG_UNUSED_B, 16'h0003);
			case (ph)
				0: set_camera(16'd0, 16'd0, vtcp_pkg::COS_RESET, 16'd0, 16'd0,
					vtcp_pkg::SIDE_DROP_NONE);
				1: set_camera(16'd1000, -16'sd2000, 16'sd11585, 16'sd11585, 16'sh7FFF,
					vtcp_pkg::SIDE_DROP_GE);
				2: set_camera(16'sh8000, 16'sh7FFF, 16'sd0, 16'sd16384, 16'sh8000,
					vtcp_pkg::SIDE_DROP_LT);
				3: set_camera(16'sh7FFF, 16'sh8000, -16'sd16384, 16'sd0, 16'sd123,
					SIDE_SPARE);
				4: set_camera(16'($urandom()), 16'($urandom()), 16'sd11585, -16'sd11585,
					16'($urandom()), vtcp_pkg::SIDE_DROP_GE);
				5: set_camera(16'($urandom()), 16'($urandom()), -16'sd16384, -16'sd16384,
					16'($urandom()), vtcp_pkg::SIDE_DROP_LT);
				6: set_camera(16'($urandom()), 16'($urandom()), 16'sd16384, 16'sd16384,
					16'($urandom()), vtcp_pkg::SIDE_DROP_NONE);
				default: set_camera(16'($urandom()), 16'($urandom()), 16'sd0, -16'sd16384,
					16'($urandom()), vtcp_pkg::SIDE_DROP_NONE);
			endcase
			send_idle = $urandom_range(0, 2) != 0;
			pop_idle = $urandom_range(0, 2) != 0;
			repeat (50) send_random_vertex();
			wait_idle();
		end

		$display("%0d vertices sent over nine camera settings, %0d projected words checked",
			board.vertices_seen, board.words_checked);
		$display("all side modes, heading extremes and register wrap values were used");
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("[vertex_transform_cull_project] OK");
		end else begin
			$display("[vertex_transform_cull_project] ERROR");
		end
		$finish;
	end
endmodule

// ===== vertex_transform_cull_project.f =====
+incdir+rtl
rtl/vtcp_pkg.sv
rtl/vtcp_fifo.sv
rtl/vtcp_front.sv
rtl/vtcp_back.sv
rtl/vertex_transform_cull_project.sv
verif/vertex_transform_cull_project_tb.sv
